>>> hw/rtl/tft_pkg.sv
// ----------------------------------------------------------------------------
// tft_pkg: TCP flow table update package
// Header constants, record status codes and the unpacked request layout
// shared by the flow table logic.
// ----------------------------------------------------------------------------
package tft_pkg;

  // Header constants
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [2:0]  WORD_BYTES     = 3'd4;
  localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
  localparam logic [15:0] IP_BASE_BYTES  = 16'd20;
  localparam logic [15:0] TCP_HDR_BYTES  = 16'd20;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  // Packed widths of the request and result words
  localparam int unsigned IN_BITS    = 237;
  localparam int unsigned IN_BYTES_W = 240;
  localparam int unsigned OUT_BITS   = 19;
  localparam int unsigned OUT_BYTES_W = 24;

  // Record status codes
  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_UPDATED = 2'd1,
    ST_NEW     = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // One packet request, fields in port order
  typedef struct packed {
    logic [63:0] time_now;
    logic [15:0] captured_bytes;
    logic [15:0] packet_length;
    logic        tcp_fin;
    logic [15:0] dst_port_num;
    logic [15:0] src_port_num;
    logic [31:0] dst_address;
    logic [31:0] src_address;
    logic [7:0]  ip_protocol;
    logic [3:0]  ip_header_words;
    logic [15:0] ether_type;
    logic [15:0] ingress_port;
  } item_t;

  // One result
  typedef struct packed {
    logic [15:0] full_event_port;
    status_t     record_status;
    logic        verdict;
  } result_t;

endpackage

>>> hw/rtl/tcp_flow_table_update_top.sv
// ----------------------------------------------------------------------------
// tcp_flow_table_update_top: TCP flow table update
// Classifies one packet header per request and keeps a small fully
// associative table of TCP flow records with counters and time stamps.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one packet request per transfer: header
//   fields, captured length and a nanosecond time stamp. Master channel
//   m_* returns exactly one result per request: verdict, record status and
//   the ingress port when the table is full.
//   The request register loads on the accepting edge; the parallel key
//   match over all FLOW_ENTRIES entries, the counter update and the result
//   register follow in a single pass on the edge where the request stage
//   advances. Throughput is one request per cycle while m_tready stays
//   high; each request sees the table as left by the one before it, since
//   the table is written on the same edge that loads the result
//   register.
//   Reset clears all entry valid bits at once, so the table starts empty
//   and a request is taken in the first cycle after reset. Entries are
//   never freed except by reset.
//   When m_tready is low the result register holds, the request register
//   fills, and s_tready falls; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tcp_flow_table_update_top #(
  parameter int unsigned FLOW_ENTRIES = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // from bit 0: ingress_port[16], ether_type[16], ip_header_words[4],
  // ip_protocol[8], src_address[32], dst_address[32], src_port_num[16],
  // dst_port_num[16], tcp_fin[1], packet_length[16], captured_bytes[16],
  // time_now[64], zero fill[3]
  input  logic [tft_pkg::IN_BYTES_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // from bit 0: verdict[1], record_status[2], full_event_port[16],
  // zero fill[5]
  output logic [tft_pkg::OUT_BYTES_W-1:0]   m_tdata
);

  localparam int unsigned IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

  // Request register
  logic           req_valid;
  tft_pkg::item_t req;
  logic           advance;

  // Flow table
  logic [FLOW_ENTRIES-1:0] entry_valid;
  logic [15:0] key_port        [FLOW_ENTRIES];
  logic [31:0] key_src_address [FLOW_ENTRIES];
  logic [31:0] key_dst_address [FLOW_ENTRIES];
  logic [31:0] key_ports       [FLOW_ENTRIES];
  logic [7:0]  key_protocol    [FLOW_ENTRIES];
  logic [31:0] packet_count    [FLOW_ENTRIES];
  logic [31:0] byte_count      [FLOW_ENTRIES];
  logic [63:0] start_time      [FLOW_ENTRIES];
  logic [63:0] end_time        [FLOW_ENTRIES];
  logic [FLOW_ENTRIES-1:0] fin_seen;

  // Lookup and result
  logic                    hdr_drop;
  logic                    tcp_short;
  logic                    is_tcp;
  logic [16:0]             tcp_need;
  logic [31:0]             req_ports;
  logic [FLOW_ENTRIES-1:0] hit_vec;
  logic                    hit;
  logic [IDX_W-1:0]        hit_idx;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;
  logic                    do_update;
  logic                    do_insert;
  tft_pkg::result_t        result_next;
  tft_pkg::result_t        result;

  // Handshake: the request stage moves when the result register is free
  assign advance  = req_valid && (!m_tvalid || m_tready);
  assign s_tready = !req_valid || advance;

  // Hold the request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      req <= s_tdata[tft_pkg::IN_BITS-1:0];
    end
  end

  // Header length and type checks
  assign tcp_need  = 17'(tft_pkg::ETH_HDR_BYTES) + 17'(tft_pkg::TCP_HDR_BYTES)
                   + 17'(7'(req.ip_header_words) * 7'(tft_pkg::WORD_BYTES));
  assign hdr_drop  = (req.captured_bytes < tft_pkg::ETH_HDR_BYTES)
                  || (req.ether_type != tft_pkg::ETHERTYPE_IPV4)
                  || (17'(req.captured_bytes) <
                      17'(tft_pkg::ETH_HDR_BYTES) + 17'(tft_pkg::IP_BASE_BYTES))
                  || (req.ip_header_words < tft_pkg::MIN_IHL);
  assign is_tcp    = (req.ip_protocol == tft_pkg::PROTO_TCP);
  assign tcp_short = 17'(req.captured_bytes) < tcp_need;
  assign req_ports = {req.src_port_num, req.dst_port_num};

  // Match every valid entry against the key in parallel
  always_comb begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      hit_vec[i] = entry_valid[i]
                && (key_port[i] == req.ingress_port)
                && (key_src_address[i] == req.src_address)
                && (key_dst_address[i] == req.dst_address)
                && (key_ports[i] == req_ports)
                && (key_protocol[i] == req.ip_protocol);
    end
  end

  // Pick the lowest matching entry and the lowest free entry
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Decide the outcome
  always_comb begin
    do_update   = 1'b0;
    do_insert   = 1'b0;
    result_next = '{full_event_port: 16'd0, record_status: tft_pkg::ST_NONE,
                    verdict: 1'b0};
    if (hdr_drop) begin
      result_next.verdict = 1'b1;
    end else if (!is_tcp) begin
      result_next.verdict = 1'b0;
    end else if (tcp_short) begin
      result_next.verdict = 1'b1;
    end else if (hit) begin
      do_update                 = 1'b1;
      result_next.record_status = tft_pkg::ST_UPDATED;
    end else if (free_found) begin
      do_insert                 = 1'b1;
      result_next.record_status = tft_pkg::ST_NEW;
    end else begin
      result_next.record_status   = tft_pkg::ST_FULL;
      result_next.full_event_port = req.ingress_port;
    end
  end

  // Update the table on the edge that takes the result
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (advance && do_insert) begin
      entry_valid[free_idx] <= 1'b1;
    end
    if (advance && do_update) begin
      packet_count[hit_idx] <= packet_count[hit_idx] + 32'd1;
      byte_count[hit_idx]   <= byte_count[hit_idx] + 32'(req.packet_length);
      end_time[hit_idx]     <= req.time_now;
      fin_seen[hit_idx]     <= fin_seen[hit_idx] | req.tcp_fin;
    end
    if (advance && do_insert) begin
      key_port[free_idx]        <= req.ingress_port;
      key_src_address[free_idx] <= req.src_address;
      key_dst_address[free_idx] <= req.dst_address;
      key_ports[free_idx]       <= req_ports;
      key_protocol[free_idx]    <= req.ip_protocol;
      packet_count[free_idx]    <= 32'd1;
      byte_count[free_idx]      <= 32'(req.packet_length);
      start_time[free_idx]      <= req.time_now;
      end_time[free_idx]        <= 64'd0;
      fin_seen[free_idx]        <= req.tcp_fin;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= req_valid;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_tdata = {(tft_pkg::OUT_BYTES_W - tft_pkg::OUT_BITS)'(0), result};

`ifndef SYNTHESIS
  // At most one valid entry matches any key
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    req_valid |-> $onehot0(hit_vec))
    else $error("more than one flow entry matches the key");

  // Table full is reported only with every entry in use
  a_full_all_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.record_status == tft_pkg::ST_FULL) |-> (&entry_valid))
    else $error("table full reported with a free entry");

  // Entries are never released outside reset
  a_valid_sticky: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((entry_valid & $past(entry_valid)) == $past(entry_valid)))
    else $error("flow entry lost its valid bit");

  // A dropped packet is never recorded
  a_drop_unrecorded: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.verdict) |->
      (result.record_status == tft_pkg::ST_NONE && result.full_event_port == 16'd0))
    else $error("dropped packet carries a record status");

  // An insert always lands on a free entry
  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    (advance && do_insert) |-> !entry_valid[free_idx])
    else $error("new flow written over a valid entry");
`endif

endmodule

>>> tb/tb_tcp_flow_table_update_top.sv
// ----------------------------------------------------------------------------
// tb_tcp_flow_table_update_top: TCP flow table update testbench
// Drives packet header requests into the stream slave port and checks every
// result against a flow table tracker kept alongside the block. It covers
// the header length and type checks and non-TCP traffic. It fills the
// table, then checks flow hits and the table full report. Random traffic
// follows under varying idle rates and back-pressure.
// ----------------------------------------------------------------------------
module tb_tcp_flow_table_update_top;

  localparam int unsigned TABLE_DEPTH = 6;
  localparam int unsigned FLOW_POOL   = 8;
  localparam int unsigned QUIET_LIMIT = 2000;

  // Header rules, kept apart from the package copies
  localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
  localparam logic [7:0]  TCP_PROTOCOL   = 8'd6;
  localparam logic [7:0]  ICMP_PROTOCOL  = 8'd1;
  localparam logic [7:0]  UDP_PROTOCOL   = 8'd17;
  localparam int unsigned IHL_MIN        = 5;
  localparam int unsigned HDR_ETH        = 14;
  localparam int unsigned HDR_IP         = 20;
  localparam int unsigned HDR_TCP        = 20;

  typedef struct {
    logic [15:0] port;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
  } flow_key_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // from bit 0: item_t fields, zero fill[3]
  logic [tft_pkg::IN_BYTES_W-1:0] s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // from bit 0: verdict[1], record_status[2], full_event_port[16], zero fill[5]
  logic [tft_pkg::OUT_BYTES_W-1:0] m_tdata;

  // Flow table tracker
  logic        flow_used  [TABLE_DEPTH];
  logic [15:0] flow_port  [TABLE_DEPTH];
  logic [31:0] flow_saddr [TABLE_DEPTH];
  logic [31:0] flow_daddr [TABLE_DEPTH];
  logic [31:0] flow_ports [TABLE_DEPTH];
  logic [7:0]  flow_proto [TABLE_DEPTH];
  logic [31:0] flow_pkts  [TABLE_DEPTH];
  logic [31:0] flow_bytes [TABLE_DEPTH];
  logic [63:0] flow_start [TABLE_DEPTH];
  logic [63:0] flow_end   [TABLE_DEPTH];
  logic        flow_fin   [TABLE_DEPTH];

  tft_pkg::result_t pending_verdicts[$];
  flow_key_t known_flows[FLOW_POOL];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_cycles = 0;

  tcp_flow_table_update_top #(
    .FLOW_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) flow_used[i] = 1'b0;
  end

  // Work out the result of one packet and update the tracked table
  function automatic tft_pkg::result_t classify_packet(input tft_pkg::item_t p);
    tft_pkg::result_t r;
    int          hit;
    int          free_idx;
    logic [31:0] ports;
    int unsigned cap;
    int unsigned need;
    r = '0;
    r.record_status = tft_pkg::ST_NONE;
    hit = -1;
    free_idx = -1;
    ports = {p.src_port_num, p.dst_port_num};
    cap = 32'(p.captured_bytes);
    need = HDR_ETH + 4 * p.ip_header_words + HDR_TCP;
    if (cap < HDR_ETH || p.ether_type != IPV4_ETHERTYPE || cap < HDR_ETH + HDR_IP ||
        p.ip_header_words < IHL_MIN) begin
      r.verdict = 1'b1;
      return r;
    end
    if (p.ip_protocol != TCP_PROTOCOL) return r;
    if (cap < need) begin
      r.verdict = 1'b1;
      return r;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (flow_used[i]) begin
        if (hit < 0 && flow_port[i] == p.ingress_port && flow_saddr[i] == p.src_address &&
            flow_daddr[i] == p.dst_address && flow_ports[i] == ports &&
            flow_proto[i] == p.ip_protocol)
          hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit >= 0) begin
      flow_pkts[hit]  = flow_pkts[hit] + 32'd1;
      flow_bytes[hit] = flow_bytes[hit] + 32'(p.packet_length);
      flow_end[hit]   = p.time_now;
      flow_fin[hit]   = flow_fin[hit] | p.tcp_fin;
      r.record_status = tft_pkg::ST_UPDATED;
    end else if (free_idx >= 0) begin
      flow_used[free_idx]  = 1'b1;
      flow_port[free_idx]  = p.ingress_port;
      flow_saddr[free_idx] = p.src_address;
      flow_daddr[free_idx] = p.dst_address;
      flow_ports[free_idx] = ports;
      flow_proto[free_idx] = p.ip_protocol;
      flow_pkts[free_idx]  = 32'd1;
      flow_bytes[free_idx] = 32'(p.packet_length);
      flow_start[free_idx] = p.time_now;
      flow_end[free_idx]   = '0;
      flow_fin[free_idx]   = p.tcp_fin;
      r.record_status = tft_pkg::ST_NEW;
    end else begin
      r.record_status   = tft_pkg::ST_FULL;
      r.full_event_port = p.ingress_port;
    end
    return r;
  endfunction

  // Check each result, then predict each accepted request
  always @(posedge clk) begin
    tft_pkg::result_t got;
    tft_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[tft_pkg::OUT_BITS-1:0];
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.verdict !== want.verdict) begin
          $display("%0t: verdict expected %0d got %0d", $time, want.verdict, got.verdict);
          mismatch_count++;
        end
        if (got.record_status !== want.record_status) begin
          $display("%0t: record_status expected %0d got %0d", $time,
                   want.record_status, got.record_status);
          mismatch_count++;
        end
        if (got.full_event_port !== want.full_event_port) begin
          $display("%0t: full_event_port expected %h got %h", $time,
                   want.full_event_port, got.full_event_port);
          mismatch_count++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready)
      pending_verdicts.push_back(classify_packet(s_tdata[tft_pkg::IN_BITS-1:0]));
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_packet(input tft_pkg::item_t p);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(tft_pkg::IN_BYTES_W - tft_pkg::IN_BITS){1'b0}}, p};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_all_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  function automatic tft_pkg::item_t build_packet(input flow_key_t k,
                                                  input logic [15:0] etype,
                                                  input logic [3:0] ihl,
                                                  input logic [7:0] proto,
                                                  input logic [15:0] cap, input logic fin,
                                                  input logic [15:0] plen);
    tft_pkg::item_t p;
    p.ingress_port    = k.port;
    p.ether_type      = etype;
    p.ip_header_words = ihl;
    p.ip_protocol     = proto;
    p.src_address     = k.saddr;
    p.dst_address     = k.daddr;
    p.src_port_num    = k.sport;
    p.dst_port_num    = k.dport;
    p.tcp_fin         = fin;
    p.packet_length   = plen;
    p.captured_bytes  = cap;
    p.time_now        = {$urandom, $urandom};
    return p;
  endfunction

  // Flip one bit of one key field, so the key just misses
  function automatic flow_key_t near_miss(input flow_key_t k);
    int b;
    b = $urandom_range(31);
    case ($urandom_range(4))
      0: k.port[b % 16]  = ~k.port[b % 16];
      1: k.saddr[b]      = ~k.saddr[b];
      2: k.daddr[b]      = ~k.daddr[b];
      3: k.sport[b % 16] = ~k.sport[b % 16];
      default: k.dport[b % 16] = ~k.dport[b % 16];
    endcase
    return k;
  endfunction

  // Mostly well-formed TCP on known flows, then non-TCP and raw noise
  function automatic tft_pkg::item_t random_packet();
    tft_pkg::item_t p;
    flow_key_t      k;
    logic [255:0]   raw;
    logic [3:0]     ihl;
    int unsigned    need;
    int             sel;
    sel  = $urandom_range(99);
    ihl  = 4'($urandom_range(15, IHL_MIN));
    need = HDR_ETH + 4 * ihl + HDR_TCP;
    raw  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (sel < 78) begin
      k = known_flows[$urandom_range(FLOW_POOL - 1)];
      if (sel >= 70) k = near_miss(k);
      p = build_packet(k, IPV4_ETHERTYPE, ihl, TCP_PROTOCOL, 16'(need),
                       1'($urandom_range(1)), 16'($urandom_range(65535)));
      case ($urandom_range(5))
        0: p.captured_bytes = 16'(need - 1);
        1: p.captured_bytes = 16'(need);
        default: p.captured_bytes = 16'($urandom_range(65535, need));
      endcase
    end else if (sel < 88) begin
      p = raw[tft_pkg::IN_BITS-1:0];
      p.ether_type = IPV4_ETHERTYPE;
      if (p.ip_protocol == TCP_PROTOCOL) p.ip_protocol = UDP_PROTOCOL;
    end else begin
      p = raw[tft_pkg::IN_BITS-1:0];
      if ($urandom_range(1)) p.ether_type = IPV4_ETHERTYPE;
    end
    return p;
  endfunction

  // Short frames, wrong ethertype, small IHL, non-TCP and the TCP length edge
  task automatic test_header_checks();
    flow_key_t k;
    k = known_flows[2];
    send_packet(build_packet(k, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd0, 1'b0, 16'd64));
    send_packet(build_packet(k, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd13, 1'b0, 16'd64));
    send_packet(build_packet(k, 16'h86DD, 4'd5, TCP_PROTOCOL, 16'd1500, 1'b0, 16'd64));
    send_packet(build_packet(k, 16'hF7FF, 4'd5, TCP_PROTOCOL, 16'd1500, 1'b1, 16'd64));
    send_packet(build_packet(k, 16'h0801, 4'd5, TCP_PROTOCOL, 16'd1500, 1'b0, 16'd64));
    send_packet(build_packet(k, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd33, 1'b0, 16'd64));
    send_packet(build_packet(k, IPV4_ETHERTYPE, 4'd4, TCP_PROTOCOL, 16'd1500, 1'b0, 16'd64));
    send_packet(build_packet(k, IPV4_ETHERTYPE, 4'd0, TCP_PROTOCOL, 16'd1500, 1'b0, 16'd64));
    send_packet(build_packet(k, IPV4_ETHERTYPE, 4'd5, ICMP_PROTOCOL, 16'd34, 1'b0, 16'd64));
    send_packet(build_packet(k, IPV4_ETHERTYPE, 4'd15, 8'hFF, 16'd34, 1'b1, 16'd64));
    send_packet(build_packet(k, IPV4_ETHERTYPE, 4'd15, TCP_PROTOCOL, 16'd93, 1'b0, 16'd64));
    send_packet(build_packet(k, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd53, 1'b0, 16'd64));
    // Exactly long enough: opens the first flow
    send_packet(build_packet(known_flows[0], IPV4_ETHERTYPE, 4'd15, TCP_PROTOCOL, 16'd94,
                             1'b0, 16'd0));
  endtask

  // Hits on an open flow, then fill the rest of the table
  task automatic test_flow_updates();
    tft_pkg::item_t p;
    p = build_packet(known_flows[0], IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'hFFFF, 1'b1,
                     16'hFFFF);
    p.time_now = '1;
    send_packet(p);
    send_packet(build_packet(known_flows[0], IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd54,
                             1'b0, 16'd0));
    for (int i = 1; i < TABLE_DEPTH; i++)
      send_packet(build_packet(known_flows[i], IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd1500,
                               1'($urandom_range(1)), 16'($urandom_range(65535))));
  endtask

  // Misses on a full table report the port; hits still update
  task automatic test_table_full();
    flow_key_t k;
    k = known_flows[0];
    k.dport[0] = ~k.dport[0];
    send_packet(build_packet(known_flows[TABLE_DEPTH], IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL,
                             16'd1500, 1'b0, 16'd100));
    send_packet(build_packet(k, IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd1500, 1'b1, 16'd100));
    send_packet(build_packet(known_flows[1], IPV4_ETHERTYPE, 4'd5, TCP_PROTOCOL, 16'd54,
                             1'b1, 16'd100));
    send_packet(build_packet(known_flows[3], IPV4_ETHERTYPE, 4'd5, UDP_PROTOCOL, 16'd1500,
                             1'b0, 16'd100));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) send_packet(random_packet());
  endtask

  // Hold the result side off long enough to stall the request side
  task automatic test_backpressure();
    hold_cycles = 80;
    for (int i = 0; i < 12; i++) send_packet(random_packet());
    wait_all_results();
  endtask

  initial begin
    known_flows[0] = '{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
    known_flows[1] = '{16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000};
    for (int i = 2; i < FLOW_POOL; i++)
      known_flows[i] = '{16'($urandom_range(65535)), $urandom, $urandom,
                         16'($urandom_range(65535)), 16'($urandom_range(65535))};

    // Hold reset, then release it on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_gap_pct   = 35;
    recv_stall_pct = 83;
    test_header_checks();
    test_flow_updates();
    test_table_full();
    test_random_traffic(200);
    wait_all_results();

    send_gap_pct   = 83;
    recv_stall_pct = 35;
    test_random_traffic(200);
    wait_all_results();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_traffic(200);
    test_backpressure();

    // Let any stray result show up before the verdict
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tft_pkg.sv
hw/rtl/tcp_flow_table_update_top.sv
tb/tb_tcp_flow_table_update_top.sv
